### design/bary_pkg.sv
package bary_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NUM_W      = CROSS_W + FRAC_BITS;
    localparam int Q_W        = 25;
    localparam int CMP_W      = CROSS_W + Q_W;
    localparam int DIV_LAT    = Q_W + 1;
    localparam int EPS_W      = 16;

    localparam logic [Q_W-1:0] QPOS_MAX = Q_W'((1 << (Q_W - 1)) - 1);
    localparam logic [Q_W-1:0] QNEG_MAG = Q_W'(1 << (Q_W - 1));

    localparam logic [1:0] BORDER_NONE   = 2'd0;
    localparam logic [1:0] BORDER_EDGE   = 2'd1;
    localparam logic [1:0] BORDER_VERTEX = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [Q_W-1:0]        val_t;

    typedef struct packed {
        logic valid;
        logic deg;
    } ctl_t;

endpackage

### design/bary_front.sv
module bary_front (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  bary_pkg::coord_t                          pt_x,
    input  bary_pkg::coord_t                          pt_y,
    input  bary_pkg::coord_t [2:0]                    vx,
    input  bary_pkg::coord_t [2:0]                    vy,
    output bary_pkg::ctl_t                            ctl_out,
    output logic [2:0][bary_pkg::NUM_W-1:0]           num_out,
    output logic [bary_pkg::CROSS_W-1:0]              den_out,
    output logic [2:0]                                neg_out
);
    import bary_pkg::*;

    logic                             v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0]         ax_reg [2];
    logic signed [DIFF_W-1:0]         ay_reg [2];
    logic signed [DIFF_W-1:0]         ex_reg [3];
    logic signed [DIFF_W-1:0]         ey_reg [3];
    logic signed [PROD_W-1:0]         pa_reg, pb_reg;
    logic signed [PROD_W-1:0]         p_reg [3];
    logic signed [PROD_W-1:0]         q_reg [3];
    logic signed [CROSS_W-1:0]        area_reg;
    logic signed [CROSS_W-1:0]        sub_reg [3];
    logic [CROSS_W-1:0]               den_reg;
    logic [2:0][NUM_W-1:0]            num_reg;
    logic [2:0]                       neg_reg;
    logic                             deg_reg;
    logic signed [CROSS_W-1:0]        sub_abs [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sub_abs[i] = sub_reg[i][CROSS_W-1] ? -sub_reg[i] : sub_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // edge vectors
            ax_reg[0] <= DIFF_W'(vx[1]) - DIFF_W'(vx[0]);
            ay_reg[0] <= DIFF_W'(vy[1]) - DIFF_W'(vy[0]);
            ax_reg[1] <= DIFF_W'(vx[2]) - DIFF_W'(vx[0]);
            ay_reg[1] <= DIFF_W'(vy[2]) - DIFF_W'(vy[0]);
            for (int i = 0; i < 3; i++) begin
                ex_reg[i] <= DIFF_W'(vx[i]) - DIFF_W'(pt_x);
                ey_reg[i] <= DIFF_W'(vy[i]) - DIFF_W'(pt_y);
            end
            // products
            pa_reg <= PROD_W'(ax_reg[0]) * PROD_W'(ay_reg[1]);
            pb_reg <= PROD_W'(ay_reg[0]) * PROD_W'(ax_reg[1]);
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= PROD_W'(ex_reg[(i+1)%3]) * PROD_W'(ey_reg[(i+2)%3]);
                q_reg[i] <= PROD_W'(ey_reg[(i+1)%3]) * PROD_W'(ex_reg[(i+2)%3]);
            end
            // doubled areas
            area_reg <= CROSS_W'(pa_reg) - CROSS_W'(pb_reg);
            for (int i = 0; i < 3; i++) begin
                sub_reg[i] <= CROSS_W'(p_reg[i]) - CROSS_W'(q_reg[i]);
            end
            // magnitudes and signs for the divider
            den_reg <= area_reg[CROSS_W-1] ? CROSS_W'(-area_reg) : CROSS_W'(area_reg);
            deg_reg <= (area_reg == '0);
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= {CROSS_W'(sub_abs[i]), FRAC_BITS'(0)};
                neg_reg[i] <= sub_reg[i][CROSS_W-1] ^ area_reg[CROSS_W-1];
            end
        end
    end

    assign ctl_out.valid = v4_reg;
    assign ctl_out.deg   = deg_reg;
    assign num_out       = num_reg;
    assign den_out       = den_reg;
    assign neg_out       = neg_reg;

endmodule

### design/bary_div.sv
module bary_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [bary_pkg::NUM_W-1:0]    num,
    input  logic [bary_pkg::CROSS_W-1:0]  den,
    input  logic                          neg,
    output logic [bary_pkg::Q_W-1:0]      quot,
    output logic                          ovf,
    output logic                          neg_out
);
    import bary_pkg::*;

    logic [NUM_W-1:0]   rem_reg [Q_W];
    logic [CROSS_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]     q_reg   [Q_W+1];
    logic               neg_reg [Q_W+1];
    logic               ovf_reg [Q_W+1];

    // quotient must stay below 2^Q_W, else flag overflow
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
        end
    end

    // one restoring step per stage, MSB first
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int SH = Q_W - 1 - k;
        logic [CMP_W-1:0] dsh;
        logic             ge;
        assign dsh = CMP_W'(den_reg[k]) << SH;
        assign ge  = CMP_W'(rem_reg[k]) >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= {q_reg[k][Q_W-2:0], ge};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? NUM_W'(CMP_W'(rem_reg[k]) - dsh) : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign quot    = q_reg[Q_W];
    assign ovf     = ovf_reg[Q_W];
    assign neg_out = neg_reg[Q_W];

endmodule

### design/bary_sort.sv
module bary_sort (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  bary_pkg::ctl_t                  ctl_in,
    input  logic [2:0][bary_pkg::Q_W-1:0]   quot,
    input  logic [2:0]                      ovf,
    input  logic [2:0]                      neg,
    input  logic [bary_pkg::EPS_W-1:0]      eps,
    output logic                            out_valid,
    output bary_pkg::val_t [2:0]            coord,
    output logic [2:0][1:0]                 idx,
    output logic                            in_tri,
    output logic [1:0]                      kind,
    output logic [1:0]                      bidx,
    output logic                            deg
);
    import bary_pkg::*;

    ctl_t              ca_reg, cb_reg;
    logic              vo_reg;
    val_t              c_reg [3];
    val_t [2:0]        srt_reg;
    logic [2:0][1:0]   ix_reg;
    val_t [2:0]        co_reg;
    logic [2:0][1:0]   io_reg;
    logic              ins_reg, deg_reg;
    logic [1:0]        kind_reg, bidx_reg;

    logic [Q_W-1:0]    mag [3];
    logic [1:0]        rank [3];
    val_t [2:0]        srt;
    logic [2:0][1:0]   ix;
    logic              g01, g02, g12;
    val_t              eps_s, neg_eps;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [Q_W-1:0] lim;
            lim    = neg[i] ? QNEG_MAG : QPOS_MAX;
            mag[i] = (ovf[i] || quot[i] > lim) ? lim : quot[i];
        end
    end

    // stable ranks: ties go to the lower index
    always_comb begin
        g01 = c_reg[0] > c_reg[1];
        g02 = c_reg[0] > c_reg[2];
        g12 = c_reg[1] > c_reg[2];
        rank[0] = 2'(g01) + 2'(g02);
        rank[1] = 2'(!g01) + 2'(g12);
        rank[2] = 2'(!g02) + 2'(!g12);
        srt = '0;
        ix  = '0;
        for (int i = 0; i < 3; i++) begin
            srt[rank[i]] = c_reg[i];
            ix[rank[i]]  = 2'(i);
        end
    end

    assign eps_s   = val_t'({(Q_W-EPS_W)'(0), eps});
    assign neg_eps = -eps_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ca_reg.valid <= 1'b0;
            cb_reg.valid <= 1'b0;
            vo_reg       <= 1'b0;
        end else if (en) begin
            ca_reg.valid <= ctl_in.valid;
            cb_reg.valid <= ca_reg.valid;
            vo_reg       <= cb_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg.deg <= ctl_in.deg;
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= neg[i] ? val_t'(-mag[i]) : val_t'(mag[i]);
            end
            cb_reg.deg <= ca_reg.deg;
            srt_reg    <= srt;
            ix_reg     <= ix;
            deg_reg    <= cb_reg.deg;
            if (cb_reg.deg) begin
                co_reg   <= '0;
                io_reg   <= {2'd2, 2'd1, 2'd0};
                ins_reg  <= 1'b0;
                kind_reg <= BORDER_NONE;
                bidx_reg <= 2'd0;
            end else begin
                co_reg  <= srt_reg;
                io_reg  <= ix_reg;
                ins_reg <= srt_reg[0] > neg_eps;
                if (srt_reg[0] < eps_s && srt_reg[1] < eps_s) begin
                    kind_reg <= BORDER_VERTEX;
                    bidx_reg <= ix_reg[2];
                end else if (srt_reg[0] < eps_s) begin
                    kind_reg <= BORDER_EDGE;
                    bidx_reg <= ix_reg[0];
                end else begin
                    kind_reg <= BORDER_NONE;
                    bidx_reg <= 2'd0;
                end
            end
        end
    end

    assign out_valid = vo_reg;
    assign coord     = co_reg;
    assign idx       = io_reg;
    assign in_tri    = ins_reg;
    assign kind      = kind_reg;
    assign bidx      = bidx_reg;
    assign deg       = deg_reg;

endmodule

### design/triangle_barycentric_locate_top.sv
// Pipeline from an accepted input item to its result item: differences, products,
// doubled areas and magnitudes in the front end, 26 divider stages, then
// saturation, sorting and classification.
// Throughput: one item per cycle while no result stalls the output; the three restoring
// dividers are fully pipelined, one quotient bit per stage. Hold the whole pipeline while a result waits.
// Reset: synchronous active-low aresetn empties the pipeline and sets eps_threshold to 7.
module triangle_barycentric_locate_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y (16 bits each)
    input  logic [127:0] s_tdata,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // coord_low[24:0], coord_mid[49:25], coord_high[74:50], idx_low[76:75],
    // idx_mid[78:77], idx_high[80:79], inside_res[81], border_kind[83:82],
    // border_index[85:84], degenerate[86], zero[87]
    output logic [87:0]  m_tdata,
    // eps_threshold register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import bary_pkg::*;

    logic                  en;
    logic [EPS_W-1:0]      eps_reg;
    coord_t                pt_x, pt_y;
    coord_t [2:0]          vx, vy;
    ctl_t                  front_ctl;
    logic [2:0][NUM_W-1:0] num;
    logic [CROSS_W-1:0]    den;
    logic [2:0]            neg;
    logic [2:0][Q_W-1:0]   quot;
    logic [2:0]            ovf, neg_d;
    ctl_t                  ctl_pipe_reg [DIV_LAT];
    val_t [2:0]            coord;
    logic [2:0][1:0]       idx;
    logic                  in_tri, deg;
    logic [1:0]            kind, bidx;

    // advance the whole pipeline unless a finished item is held at the output
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(7);
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    // unpack the input item
    assign pt_x = s_tdata[15:0];
    assign pt_y = s_tdata[31:16];
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign vx[i] = s_tdata[32*i+47 -: 16];
        assign vy[i] = s_tdata[32*i+63 -: 16];
    end

    bary_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .pt_x     (pt_x),
        .pt_y     (pt_y),
        .vx       (vx),
        .vy       (vy),
        .ctl_out  (front_ctl),
        .num_out  (num),
        .den_out  (den),
        .neg_out  (neg)
    );

    // one divider per barycentric coordinate
    for (genvar i = 0; i < 3; i++) begin : g_div
        bary_div u_div (
            .aclk    (aclk),
            .en      (en),
            .num     (num[i]),
            .den     (den),
            .neg     (neg[i]),
            .quot    (quot[i]),
            .ovf     (ovf[i]),
            .neg_out (neg_d[i])
        );
    end

    // carry valid and degenerate alongside the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                ctl_pipe_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            ctl_pipe_reg[0].valid <= front_ctl.valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                ctl_pipe_reg[k].valid <= ctl_pipe_reg[k-1].valid;
            end
        end
        if (en) begin
            ctl_pipe_reg[0].deg <= front_ctl.deg;
            for (int k = 1; k < DIV_LAT; k++) begin
                ctl_pipe_reg[k].deg <= ctl_pipe_reg[k-1].deg;
            end
        end
    end

    bary_sort u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_pipe_reg[DIV_LAT-1]),
        .quot      (quot),
        .ovf       (ovf),
        .neg       (neg_d),
        .eps       (eps_reg),
        .out_valid (m_tvalid),
        .coord     (coord),
        .idx       (idx),
        .in_tri    (in_tri),
        .kind      (kind),
        .bidx      (bidx),
        .deg       (deg)
    );

    // pack the result item
    assign m_tdata = {1'b0, deg, bidx, kind, in_tri, idx[2], idx[1], idx[0],
                      coord[2], coord[1], coord[0]};

`ifndef ASSERT_OFF
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (coord[0] <= coord[1]) && (coord[1] <= coord[2]))
        else $error("result coordinates not in ascending order");

    a_perm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx[0] != idx[1]) && (idx[0] != idx[2]) && (idx[1] != idx[2]))
        else $error("vertex indices are not a permutation");

    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && deg) |-> (!in_tri && kind == BORDER_NONE && coord == '0))
        else $error("degenerate triangle reported with coordinates or flags");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(coord) && $stable(idx))
        else $error("stalled pipeline lost or changed an item");
`endif

endmodule

### tb/sv/triangle_barycentric_locate_top_tb.sv
`timescale 1ns / 1ps

module triangle_barycentric_locate_top_tb;
    import bary_pkg::*;

    localparam int LATENCY     = 33;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [24:0] coord_low;
        logic signed [24:0] coord_mid;
        logic signed [24:0] coord_high;
        logic [1:0]         idx_low;
        logic [1:0]         idx_mid;
        logic [1:0]         idx_high;
        logic               inside_res;
        logic [1:0]         border_kind;
        logic [1:0]         border_index;
        logic               degenerate;
    } locate_t;

    // Scoreboard: predicts each location and holds the pending ones in order.
    class locate_scoreboard;
        locate_t     pending[$];
        logic [15:0] eps;
        int          errors;
        int          checked;

        function void set_eps(logic [15:0] value);
            eps = value;
        endfunction

        function automatic logic signed [24:0] scaled_ratio(longint sub, longint area);
            logic signed [127:0] num;
            logic signed [127:0] q;
            num = 128'(sub) <<< 16;
            q   = num / 128'(area);
            if (q > 128'sd16777215) return 25'sd16777215;
            if (q < -128'sd16777216) return -25'sd16777216;
            return q[24:0];
        endfunction

        function void note_query(logic [127:0] d);
            longint  px, py, area, sub;
            longint  vx[3], vy[3];
            logic signed [24:0] c[3];
            int      idx[3];
            int      t, a, b;
            locate_t r;
            px = longint'($signed(d[15:0]));
            py = longint'($signed(d[31:16]));
            for (int i = 0; i < 3; i++) begin
                vx[i] = longint'($signed(d[32+32*i +: 16]));
                vy[i] = longint'($signed(d[48+32*i +: 16]));
                idx[i] = i;
                c[i] = '0;
            end
            area = (vx[1]-vx[0])*(vy[2]-vy[0]) - (vy[1]-vy[0])*(vx[2]-vx[0]);
            r.inside_res   = 1'b0;
            r.border_kind  = BORDER_NONE;
            r.border_index = 2'd0;
            r.degenerate   = (area == 0);
            if (area != 0) begin
                for (int i = 0; i < 3; i++) begin
                    a = (i + 1) % 3;
                    b = (i + 2) % 3;
                    sub = (vx[a]-px)*(vy[b]-py) - (vy[a]-py)*(vx[b]-px);
                    c[i] = scaled_ratio(sub, area);
                end
                // stable sort keeps the lower vertex first on ties
                for (int i = 1; i < 3; i++)
                    for (int j = i; j > 0 && c[idx[j-1]] > c[idx[j]]; j--) begin
                        t = idx[j]; idx[j] = idx[j-1]; idx[j-1] = t;
                    end
                r.inside_res = (longint'(c[idx[0]]) > -longint'(eps));
                if (longint'(c[idx[0]]) < longint'(eps)) begin
                    if (longint'(c[idx[1]]) < longint'(eps)) begin
                        r.border_kind  = BORDER_VERTEX;
                        r.border_index = 2'(idx[2]);
                    end else begin
                        r.border_kind  = BORDER_EDGE;
                        r.border_index = 2'(idx[0]);
                    end
                end
            end
            r.coord_low  = r.degenerate ? '0 : c[idx[0]];
            r.coord_mid  = r.degenerate ? '0 : c[idx[1]];
            r.coord_high = r.degenerate ? '0 : c[idx[2]];
            r.idx_low  = 2'(idx[0]);
            r.idx_mid  = 2'(idx[1]);
            r.idx_high = 2'(idx[2]);
            pending.push_back(r);
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [87:0] d);
            locate_t e;
            if (pending.size() == 0) begin
                $error("result item with no query waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            compare("coord_low", e.coord_low, $signed(d[24:0]));
            compare("coord_mid", e.coord_mid, $signed(d[49:25]));
            compare("coord_high", e.coord_high, $signed(d[74:50]));
            compare("idx_low", e.idx_low, d[76:75]);
            compare("idx_mid", e.idx_mid, d[78:77]);
            compare("idx_high", e.idx_high, d[80:79]);
            compare("inside_res", e.inside_res, d[81]);
            compare("border_kind", e.border_kind, d[83:82]);
            compare("border_index", e.border_index, d[85:84]);
            compare("degenerate", e.degenerate, d[86]);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    locate_scoreboard sb;
    int  cycle_count = 0;
    bit  calm_phase  = 1'b0;  // no idling on either side
    bit  hold_sink   = 1'b0;  // long receiver hold-off requested
    int  queries     = 0;

    triangle_barycentric_locate_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Count cycles and stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sample accepted items on the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_query(s_tdata);
            queries++;
        end
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                for (int i = 0; i < 120; i++) @(negedge aclk);
                hold_sink = 1'b0;
            end
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                m_tready <= 1'b0;
                for (int i = 1; i < n; i++) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one query and hold it until accepted; idle bursts in between.
    // Leave tvalid high on return: the next query or a drain drops it.
    task automatic send_query(logic [127:0] d);
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drain all pending results, then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Write the tolerance while the block is idle.
    task automatic write_eps(logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_eps(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [127:0] pack_query(int px, int py, int x0, int y0,
                                                int x1, int y1, int x2, int y2);
        return {16'(y2), 16'(x2), 16'(y1), 16'(x1), 16'(y0), 16'(x0),
                16'(py), 16'(px)};
    endfunction

    function automatic int rand_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Random query: mostly small triangles with nearby points, some full-range.
    function automatic logic [127:0] random_query();
        int kind, span, cx, cy;
        int v[6];
        kind = $urandom_range(0, 9);
        if (kind == 0) return {$urandom, $urandom, $urandom, $urandom};
        span = (kind < 4) ? 16 : (kind < 8) ? 1000 : 32767;
        cx = rand_coord(32767 - span);
        cy = rand_coord(32767 - span);
        for (int i = 0; i < 6; i++)
            v[i] = ((i % 2) ? cy : cx) + rand_coord(span);
        if (kind == 9) begin
            // collinear or repeated vertices
            v[4] = v[0] + (v[2] - v[0]) / 2;
            v[5] = v[1] + (v[3] - v[1]) / 2;
        end
        if (kind == 8) return pack_query(v[0], v[1], v[0], v[1], v[2], v[3], v[4], v[5]);
        return pack_query(cx + rand_coord(span), cy + rand_coord(span),
                          v[0], v[1], v[2], v[3], v[4], v[5]);
    endfunction

    initial begin
        logic [15:0] eps_list[6];
        eps_list = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd7, 16'd32768};
        sb = new();
        sb.set_eps(16'd7);
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, degenerate shapes, edges, vertices, saturation.
        send_query(pack_query(1, 1, 0, 0, 10, 0, 0, 10));
        send_query(pack_query(5, 0, 0, 0, 10, 0, 0, 10));
        send_query(pack_query(0, 0, 0, 0, 10, 0, 0, 10));
        send_query(pack_query(10, 0, 0, 0, 10, 0, 0, 10));
        send_query(pack_query(20, 20, 0, 0, 10, 0, 0, 10));
        send_query(pack_query(1, 1, 0, 0, 0, 10, 10, 0));
        send_query(pack_query(3, 3, 0, 0, 0, 0, 0, 0));
        send_query(pack_query(3, 3, 0, 0, 5, 5, 10, 10));
        send_query(pack_query(-32768, -32768, 32767, 32767, 32766, 32767, 32767, 32766));
        send_query(pack_query(32767, 32767, -32768, -32768, -32767, -32768, -32768, -32767));
        send_query(pack_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
        send_query(pack_query(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        send_query(pack_query(2, 2, 0, 0, 6, 0, 0, 6));
        send_query(pack_query(-1, -1, 0, 0, 1, 0, 0, 1));
        send_query({128{1'b1}});
        send_query('0);
        send_query(pack_query(1, 0, 0, 0, 3, 0, 0, 3));

        for (int p = 0; p < 6; p++) begin
            write_eps(eps_list[p]);
            // pause until every result is back before the next burst
            for (int i = 0; i < 200; i++) begin
                if (p == 1 && i == 20) hold_sink = 1'b1;
                if (p == 5 && i == 50) calm_phase = 1'b1;
                send_query(random_query());
            end
            drain_results();
        end
        // eps reset value already covered by phase with 7
        calm_phase = 1'b1;
        for (int i = 0; i < 130; i++) send_query(random_query());
        drain_results();

        $display("%0d queries located, %0d results checked, six tolerance settings",
                 queries, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
design/bary_pkg.sv
design/bary_front.sv
design/bary_div.sv
design/bary_sort.sv
design/triangle_barycentric_locate_top.sv
tb/sv/triangle_barycentric_locate_top_tb.sv
